// ----- hw/rtl/dss_pkg.sv -----
// Shared types and constants of the decision slew smoother.
`default_nettype none

package dss_pkg;

	// Fixed field widths
	localparam int VALUE_W   = 24;
	localparam int CHAN_W    = 4;
	localparam int TIME_W    = 32;
	localparam int COUNT_W   = 32;
	localparam int SPEED_W   = 23;
	localparam int WINDOW_W  = 16;
	localparam int CCOUNT_W  = 5;
	localparam int CFG_IDX_W = 3;
	localparam int ALPHA_W   = 17;

	localparam int MAX_CHANNELS_DEF = 16;
	localparam int QUEUE_DEPTH      = 2;

	// Command codes on the item channel
	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_TICK   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLEW_SPEED    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_STEP    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AVERAGE_MODE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EMIT_ON_EVENT = 3'd5;

	typedef enum logic [1:0] {
		OP_SAMPLE,
		OP_TICK,
		OP_CLEAR
	} op_t;

	// Classified item as queued between front and back
	typedef struct packed {
		op_t                       op;
		logic [CHAN_W-1:0]         channel;
		logic signed [VALUE_W-1:0] score;
		logic [TIME_W-1:0]         time_ms;
		logic                      last;
		logic                      in_range;
		logic                      emit;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_MUL,
		ST_SUM,
		ST_FINISH,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/decision_slew_smoother.sv -----
// Top level of the decision slew smoother.
// Smooths per-channel classifier scores and emits one decision per active
// channel on a tick, or after the last sample of an event when emit_on_event
// is set. Items enter a two-entry queue and are worked one at a time. A
// cumulative-mean sample uses the 32-step restoring divider to form the mean
// step. A windowed blend uses the same divider to form the blend weight, and
// the MUL and SUM states then form the products and their sum (outside the
// window the divider is skipped and the weight is zero). An emit walks the
// channels one per cycle while the result channel is not stalled.
// Configuration writes are always taken (ready stays high) and must only be
// made while the block is idle.
`default_nettype none

module decision_slew_smoother
	import dss_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// item channel
	input  wire logic                      item_valid,
	output logic                           item_stall,
	input  wire logic [1:0]                cmd,
	input  wire logic [CHAN_W-1:0]         channel,
	input  wire logic signed [VALUE_W-1:0] score,
	input  wire logic [TIME_W-1:0]         time_ms,
	input  wire logic                      last_of_event,
	// result channel
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output logic [CHAN_W-1:0]              out_channel,
	output logic signed [VALUE_W-1:0]      decision,
	output logic                           last_channel,
	// configuration writes
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [31:0]               cfg_data
);

	logic [CCOUNT_W-1:0] channel_count_q;
	logic [SPEED_W-1:0]  slew_speed_q, decay_step_q;
	logic                average_mode_q, emit_on_event_q;
	logic [WINDOW_W-1:0] window_ms_q;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CCOUNT_W'(1);
			slew_speed_q    <= '0;
			decay_step_q    <= '0;
			average_mode_q  <= 1'b0;
			window_ms_q     <= '0;
			emit_on_event_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[CCOUNT_W-1:0];
				REG_SLEW_SPEED:    slew_speed_q    <= cfg_data[SPEED_W-1:0];
				REG_DECAY_STEP:    decay_step_q    <= cfg_data[SPEED_W-1:0];
				REG_AVERAGE_MODE:  average_mode_q  <= cfg_data[0];
				REG_WINDOW_MS:     window_ms_q     <= cfg_data[WINDOW_W-1:0];
				REG_EMIT_ON_EVENT: emit_on_event_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	entry_t entry, head;
	logic   keep, push, pop, empty, full;
	logic [$bits(entry_t)-1:0] head_bits;

	dss_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
		.cmd           (cmd),
		.channel       (channel),
		.score         (score),
		.time_ms       (time_ms),
		.last_of_event (last_of_event),
		.channel_count (channel_count_q),
		.emit_on_event (emit_on_event_q),
		.entry         (entry),
		.keep          (keep)
	);

	assign item_stall = full;
	assign push       = item_valid && !full && keep;

	dss_queue #(.WIDTH($bits(entry_t))) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (pop),
		.rdata  (head_bits),
		.empty  (empty),
		.full   (full)
	);

	assign head = entry_t'(head_bits);

	dss_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.empty         (empty),
		.pop           (pop),
		.channel_count (channel_count_q),
		.slew_speed    (slew_speed_q),
		.decay_step    (decay_step_q),
		.average_mode  (average_mode_q),
		.window_ms     (window_ms_q),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.out_channel   (out_channel),
		.decision      (decision),
		.last_channel  (last_channel)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/dss_queue.sv -----
// Small flop FIFO between the front and the back.
`default_nettype none

module dss_queue
	import dss_pkg::*;
#(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty,
	output logic                  full
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign rdata = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dss_front.sv -----
// Front end: decodes and classifies incoming items for the queue.
`default_nettype none

module dss_front
	import dss_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  wire logic [1:0]                cmd,
	input  wire logic [CHAN_W-1:0]         channel,
	input  wire logic signed [VALUE_W-1:0] score,
	input  wire logic [TIME_W-1:0]         time_ms,
	input  wire logic                      last_of_event,
	input  wire logic [CCOUNT_W-1:0]       channel_count,
	input  wire logic                      emit_on_event,
	output entry_t                         entry,
	output logic                           keep
);

	// unused command codes are dropped here
	always_comb begin
		entry          = '0;
		keep           = 1'b1;
		entry.channel  = channel;
		entry.score    = score;
		entry.time_ms  = time_ms;
		entry.last     = last_of_event;
		entry.in_range = (8'(channel) < 8'(channel_count)) && (8'(channel) < 8'(MAX_CHANNELS));
		unique case (cmd)
			CMD_SAMPLE: begin
				entry.op   = OP_SAMPLE;
				entry.emit = last_of_event && emit_on_event;
			end
			CMD_TICK: begin
				entry.op   = OP_TICK;
				entry.emit = 1'b1;
			end
			CMD_CLEAR: begin
				entry.op   = OP_CLEAR;
				entry.emit = 1'b0;
			end
			default: begin
				entry.op   = OP_SAMPLE;
				entry.emit = 1'b0;
				keep       = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dss_div.sv -----
// Restoring divider, one quotient bit per cycle.
`default_nettype none

module dss_div
	import dss_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic [TIME_W-1:0]   dividend,
	input  wire logic [TIME_W:0]     divisor,
	output logic                     done,
	output logic      [TIME_W-1:0]   quotient
);

	localparam int STEP_W = $clog2(TIME_W);

	logic [TIME_W:0]     rem_q;
	logic [TIME_W-1:0]   dvd_q;
	logic [TIME_W:0]     dsr_q;
	logic [STEP_W-1:0]   step_q;
	logic                busy_q, done_q;
	logic [TIME_W+1:0]   rem_sh, trial;

	assign rem_sh   = {rem_q, dvd_q[TIME_W-1]};
	assign trial    = rem_sh - {1'b0, dsr_q};
	assign done     = done_q;
	assign quotient = dvd_q;

	// datapath: remainder and dividend/quotient shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[TIME_W+1]) begin
				rem_q <= trial[TIME_W:0];
				dvd_q <= {dvd_q[TIME_W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[TIME_W:0];
				dvd_q <= {dvd_q[TIME_W-2:0], 1'b0};
			end
		end
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(TIME_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/dss_back.sv -----
// Back end: channel state, target update, slew and decay walk, result register.
`default_nettype none

module dss_back
	import dss_pkg::*;
#(
	parameter int MAX_CHANNELS = MAX_CHANNELS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  entry_t                         head,
	input  wire logic                      empty,
	output logic                           pop,
	input  wire logic [CCOUNT_W-1:0]       channel_count,
	input  wire logic [SPEED_W-1:0]        slew_speed,
	input  wire logic [SPEED_W-1:0]        decay_step,
	input  wire logic                      average_mode,
	input  wire logic [WINDOW_W-1:0]       window_ms,
	output logic                           result_valid,
	input  wire logic                      result_stall,
	output logic [CHAN_W-1:0]              out_channel,
	output logic signed [VALUE_W-1:0]      decision,
	output logic                           last_channel
);

	localparam int IW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int PW   = ALPHA_W + 1 + VALUE_W;
	localparam int ONE  = 1 << (ALPHA_W - 1);

	state_t st_q, st_d;
	entry_t cur_q;

	logic signed [VALUE_W-1:0] target_q   [MAX_CHANNELS];
	logic signed [VALUE_W-1:0] decision_q [MAX_CHANNELS];
	logic [COUNT_W-1:0]        count_q;
	logic [TIME_W-1:0]         last_time_q;
	logic [ALPHA_W-1:0]        alpha_q;
	logic signed [PW-1:0]      p1_q, p2_q;
	logic [IW-1:0]             idx_q;
	logic                      rvalid_q;
	logic [CHAN_W-1:0]         rchan_q;
	logic signed [VALUE_W-1:0] rdec_q;
	logic                      rlast_q;

	// control from the output decoder
	logic pop_c, div_start, tgt_we, clear_all, emit_go, alpha_zero, alpha_ld, mul_go, finish_go;
	logic signed [VALUE_W-1:0] tgt_wdata;

	// shared reads
	logic [IW-1:0]             rd_idx;
	logic signed [VALUE_W-1:0] t_rd, d_rd;
	logic [7:0]                n_act;
	logic                      mean_sel, blend_ok, last_e, out_free;
	logic [TIME_W-1:0]         delta;

	assign rd_idx   = (st_q == ST_EMIT) ? idx_q : IW'(cur_q.channel);
	assign t_rd     = target_q[rd_idx];
	assign d_rd     = decision_q[rd_idx];
	assign n_act    = (8'(channel_count) > 8'(MAX_CHANNELS)) ? 8'(MAX_CHANNELS)
	                                                         : 8'(channel_count);
	assign mean_sel = average_mode && (window_ms == '0);
	assign delta    = cur_q.time_ms - last_time_q;
	assign blend_ok = delta <= TIME_W'(window_ms);
	assign last_e   = (8'(idx_q) + 8'd1) == n_act;
	assign out_free = !rvalid_q || !result_stall;

	// mean step and blend weight operands
	logic signed [VALUE_W:0]   diff;
	logic                      neg;
	logic [VALUE_W:0]          mag;
	logic [TIME_W-1:0]         div_dvd, quot;
	logic [TIME_W:0]           div_dsr;
	logic                      div_done;
	logic signed [VALUE_W+1:0] qs, t_mean26;

	assign diff    = {cur_q.score[VALUE_W-1], cur_q.score} - {t_rd[VALUE_W-1], t_rd};
	assign neg     = diff[VALUE_W];
	assign mag     = neg ? -diff : diff;
	assign div_dvd = mean_sel ? TIME_W'(mag) : {window_ms - delta[WINDOW_W-1:0], 16'b0};
	assign div_dsr = mean_sel ? (TIME_W+1)'(count_q) + 1'b1 : (TIME_W+1)'(window_ms);
	assign qs      = neg ? -$signed({1'b0, quot[VALUE_W:0]}) : $signed({1'b0, quot[VALUE_W:0]});
	assign t_mean26 = {{2{t_rd[VALUE_W-1]}}, t_rd} + qs;

	dss_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.done     (div_done),
		.quotient (quot)
	);

	// blend sum after the product register
	logic signed [PW:0] bsum;
	assign bsum = {p1_q[PW-1], p1_q} + {p2_q[PW-1], p2_q} + (PW+1)'(ONE / 2);

	// slew and decay for the channel being emitted
	logic signed [VALUE_W:0] d25, t25, sum_up, sum_dn, dn, td;
	logic signed [VALUE_W-1:0] t_dec;
	assign d25    = {d_rd[VALUE_W-1], d_rd};
	assign t25    = {t_rd[VALUE_W-1], t_rd};
	assign sum_up = d25 + $signed({2'b0, slew_speed});
	assign sum_dn = d25 - $signed({2'b0, slew_speed});
	always_comb begin
		if (slew_speed == '0) begin
			dn = t25;
		end else if (d25 < t25) begin
			dn = (sum_up > t25) ? t25 : sum_up;
		end else if (d25 > t25) begin
			dn = (sum_dn < t25) ? t25 : sum_dn;
		end else begin
			dn = d25;
		end
	end
	assign td    = t25 - $signed({2'b0, decay_step});
	assign t_dec = td[VALUE_W] ? '0 : td[VALUE_W-1:0];

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (!empty) st_d = ST_START;
			ST_START: begin
				priority case (cur_q.op)
					OP_CLEAR: st_d = ST_IDLE;
					OP_TICK:  st_d = (n_act != '0) ? ST_EMIT : ST_IDLE;
					default: begin
						if (!cur_q.in_range || !average_mode) st_d = ST_FINISH;
						else if (mean_sel || blend_ok)        st_d = ST_DIV;
						else                                  st_d = ST_MUL;
					end
				endcase
			end
			ST_DIV:    if (div_done) st_d = mean_sel ? ST_FINISH : ST_MUL;
			ST_MUL:    st_d = ST_SUM;
			ST_SUM:    st_d = ST_FINISH;
			ST_FINISH: st_d = (cur_q.emit && n_act != '0) ? ST_EMIT : ST_IDLE;
			ST_EMIT:   if (out_free && last_e) st_d = ST_IDLE;
			default:   st_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		pop_c      = 1'b0;
		div_start  = 1'b0;
		tgt_we     = 1'b0;
		tgt_wdata  = cur_q.score;
		clear_all  = 1'b0;
		emit_go    = 1'b0;
		alpha_zero = 1'b0;
		alpha_ld   = 1'b0;
		mul_go     = 1'b0;
		finish_go  = 1'b0;
		unique case (st_q)
			ST_IDLE: pop_c = !empty;
			ST_START: begin
				if (cur_q.op == OP_CLEAR) begin
					clear_all = 1'b1;
				end else if (cur_q.op == OP_SAMPLE && cur_q.in_range) begin
					if (!average_mode) begin
						tgt_we = 1'b1;
					end else if (mean_sel || blend_ok) begin
						div_start = 1'b1;
					end else begin
						alpha_zero = 1'b1;
					end
				end
			end
			ST_DIV: begin
				if (div_done && mean_sel) begin
					tgt_we    = 1'b1;
					tgt_wdata = t_mean26[VALUE_W-1:0];
				end else if (div_done) begin
					alpha_ld = 1'b1;
				end
			end
			ST_MUL: mul_go = 1'b1;
			ST_SUM: begin
				tgt_we    = 1'b1;
				tgt_wdata = bsum[VALUE_W+15:16];
			end
			ST_FINISH: finish_go = 1'b1;
			ST_EMIT:   emit_go   = out_free;
			default: ;
		endcase
	end

	assign pop = pop_c;

	// datapath registers
	always_ff @(posedge clk) begin
		if (pop_c) cur_q <= head;
		if (alpha_zero) alpha_q <= '0;
		else if (alpha_ld) alpha_q <= quot[ALPHA_W-1:0];
		if (mul_go) begin
			p1_q <= PW'($signed({1'b0, alpha_q}) * t_rd);
			p2_q <= PW'($signed(18'(ONE) - {1'b0, alpha_q}) * cur_q.score);
		end
		if (emit_go) begin
			rchan_q <= CHAN_W'(idx_q);
			rdec_q  <= dn[VALUE_W-1:0];
			rlast_q <= last_e;
		end
	end

	// channel state and control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			count_q     <= '0;
			last_time_q <= '0;
			idx_q       <= '0;
			rvalid_q    <= 1'b0;
			for (int i = 0; i < MAX_CHANNELS; i++) begin
				target_q[i]   <= '0;
				decision_q[i] <= '0;
			end
		end else begin
			st_q <= st_d;
			if (clear_all) begin
				count_q <= '0;
				for (int i = 0; i < MAX_CHANNELS; i++) begin
					target_q[i] <= '0;
				end
			end
			if (tgt_we) target_q[rd_idx] <= tgt_wdata;
			if (finish_go) begin
				idx_q <= '0;
				if (cur_q.last) begin
					last_time_q <= cur_q.time_ms;
					if (mean_sel && count_q != '1) count_q <= count_q + 1'b1;
				end
			end
			if (st_q == ST_START && cur_q.op == OP_TICK) idx_q <= '0;
			if (emit_go) begin
				decision_q[idx_q] <= dn[VALUE_W-1:0];
				target_q[idx_q]   <= t_dec;
				idx_q             <= idx_q + 1'b1;
			end
			// result register: loaded by the walk, freed by a transfer
			if (emit_go)           rvalid_q <= 1'b1;
			else if (!result_stall) rvalid_q <= 1'b0;
		end
	end

	assign result_valid = rvalid_q;
	assign out_channel  = rchan_q;
	assign decision     = rdec_q;
	assign last_channel = rlast_q;

endmodule

`default_nettype wire
